// ----- rtl/md5_pkg.sv -----
// Shared types, constants and round tables for the MD5 digest unit.
package md5_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned PosW       = $clog2(BlockWords);
  localparam int unsigned LenW       = 64;
  localparam int unsigned RoundW     = 6;
  localparam int unsigned NumRounds  = 64;

  localparam logic [WordW-1:0] Iv0     = 32'h67452301;
  localparam logic [WordW-1:0] Iv1     = 32'hEFCDAB89;
  localparam logic [WordW-1:0] Iv2     = 32'h98BADCFE;
  localparam logic [WordW-1:0] Iv3     = 32'h10325476;
  localparam logic [7:0]       PadByte = 8'h80;
  localparam logic [PosW-1:0]  LenLoPos = 4'd14;
  localparam logic [PosW-1:0]  LenHiPos = 4'd15;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StRound,
    StFold,
    StOut
  } md5_state_e;

  function automatic logic [WordW-1:0] sine_k(input logic [RoundW-1:0] r);
    logic [WordW-1:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] shift_amt(input logic [RoundW-1:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word used by a round, mod 16
  function automatic logic [PosW-1:0] msg_index(input logic [RoundW-1:0] r);
    logic [PosW-1:0] lo;
    logic [PosW-1:0] idx;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = (lo << 2) + lo + 4'd1;
      2'd2:    idx = (lo << 1) + lo + 4'd5;
      default: idx = (lo << 3) - lo;
    endcase
    return idx;
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
                                            input logic [4:0] s);
    logic [2*WordW-1:0] t;
    t = {v, v} << s;
    return t[2*WordW-1:WordW];
  endfunction

endpackage

// ----- rtl/md5_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/md5_message_digest_unit.sv -----
// MD5 digest unit: message word stream in, four digest words out.
//
//   channel | dir | tdata                               | tlast
//   s_axis  | in  | [31:0] message_word, [34:32] valid_bytes | last_word
//   m_axis  | out | [31:0] digest_word                  | digest_last
//
// A message word is taken whenever the unit is idle; the block words sit in a 16x32 RAM.
// Each sixteenth word starts a compression: one read lead, 64 rounds
// (one round a cycle, bounded by the RAM read port), one fold into the hash.
// After a last word, padding writes one word a cycle, then four digest items.
// Reset is asynchronous; no clearing pass is needed after it.
// While compressing, padding or holding a digest, s_axis_tready_o is low.
module md5_message_digest_unit
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [31:0] message_word, [34:32] valid_bytes
  input  logic        s_axis_tlast_i,  // last_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] digest_word
  output logic        m_axis_tlast_o   // digest_last
);

  md5_state_e       state_q, state_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [LenW-1:0]  bitlen_q, bitlen_d;
  logic             pad_q, pad_d;
  logic             pad80_q, pad80_d;
  logic             lenlo_q, lenlo_d;
  logic             fin_q, fin_d;
  logic [RoundW:0]  round_q, round_d;
  logic [1:0]       oidx_q, oidx_d;
  logic [WordW-1:0] cv_q [4];
  logic [WordW-1:0] cv_d [4];
  logic [WordW-1:0] wv_q [4];
  logic [WordW-1:0] wv_d [4];

  logic             in_acc, out_acc;
  logic             wr_en;
  logic [WordW-1:0] wr_data;
  logic [PosW-1:0]  rd_addr;
  logic [WordW-1:0] rd_data;
  logic [WordW-1:0] in_word;
  logic [2:0]       in_count;
  logic [WordW-1:0] last_word;
  logic [WordW-1:0] pad_word;
  logic [RoundW:0]  round_m1;
  logic [RoundW-1:0] rnd;
  logic [WordW-1:0] mix, sum;

  assign in_word  = s_axis_tdata_i[31:0];
  assign in_count = (s_axis_tdata_i[34:32] > 3'd4) ? 3'd4 : s_axis_tdata_i[34:32];
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    case (in_count)
      3'd0:    last_word = {24'h0, PadByte};
      3'd1:    last_word = {16'h0, PadByte, in_word[7:0]};
      3'd2:    last_word = {8'h0, PadByte, in_word[15:0]};
      3'd3:    last_word = {PadByte, in_word[23:0]};
      default: last_word = in_word;
    endcase
  end

  always_comb begin
    if (pad80_q) begin
      pad_word = {24'h0, PadByte};
    end else if (pos_q == LenLoPos) begin
      pad_word = bitlen_q[31:0];
    end else if (pos_q == LenHiPos && lenlo_q) begin
      pad_word = bitlen_q[63:32];
    end else begin
      pad_word = '0;
    end
  end

  md5_ram #(
    .Width(WordW),
    .Depth(BlockWords)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(pos_q),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (pos_q == LenHiPos) begin
            state_d = StRound;
          end else if (s_axis_tlast_i) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        if (pos_q == LenHiPos) begin
          state_d = StRound;
        end
      end
      StRound: begin
        if (round_q == (RoundW+1)'(NumRounds)) begin
          state_d = StFold;
        end
      end
      StFold: begin
        if (fin_q) begin
          state_d = StOut;
        end else if (pad_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_acc && oidx_q == 2'd3) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    wr_en           = 1'b0;
    wr_data         = pad_word;
    rd_addr         = msg_index(round_q[RoundW-1:0]);
    unique case (state_q)
      StIdle: begin
        s_axis_tready_o = 1'b1;
        wr_en           = s_axis_tvalid_i;
        wr_data         = s_axis_tlast_i ? last_word : in_word;
      end
      StPad:   wr_en = 1'b1;
      StOut:   m_axis_tvalid_o = 1'b1;
      default: ;
    endcase
  end

  assign m_axis_tdata_o = cv_q[oidx_q];
  assign m_axis_tlast_o = (oidx_q == 2'd3);

  assign round_m1 = round_q - (RoundW+1)'(1);
  assign rnd      = round_m1[RoundW-1:0];

  always_comb begin
    case (rnd[5:4])
      2'd0:    mix = (wv_q[1] & wv_q[2]) | (~wv_q[1] & wv_q[3]);
      2'd1:    mix = (wv_q[3] & wv_q[1]) | (~wv_q[3] & wv_q[2]);
      2'd2:    mix = wv_q[1] ^ wv_q[2] ^ wv_q[3];
      default: mix = wv_q[2] ^ (wv_q[1] | ~wv_q[3]);
    endcase
    sum = wv_q[0] + mix + sine_k(rnd) + rd_data;
  end

  // datapath
  always_comb begin
    pos_d    = pos_q;
    bitlen_d = bitlen_q;
    pad_d    = pad_q;
    pad80_d  = pad80_q;
    lenlo_d  = lenlo_q;
    fin_d    = fin_q;
    round_d  = round_q;
    oidx_d   = oidx_q;
    cv_d     = cv_q;
    wv_d     = wv_q;

    if (wr_en) begin
      pos_d = pos_q + PosW'(1);
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tlast_i) begin
            bitlen_d = bitlen_q + LenW'({in_count, 3'b000});
            pad_d    = 1'b1;
            pad80_d  = (in_count == 3'd4);
          end else begin
            bitlen_d = bitlen_q + LenW'(WordW);
          end
        end
      end
      StPad: begin
        if (pad80_q) begin
          pad80_d = 1'b0;
        end else if (pos_q == LenLoPos) begin
          lenlo_d = 1'b1;
        end else if (pos_q == LenHiPos && lenlo_q) begin
          fin_d = 1'b1;
        end
      end
      StRound: begin
        round_d = round_q + (RoundW+1)'(1);
        if (round_q != '0) begin
          wv_d[0] = wv_q[3];
          wv_d[1] = wv_q[1] + rotl(sum, shift_amt(rnd));
          wv_d[2] = wv_q[1];
          wv_d[3] = wv_q[2];
        end
      end
      StFold: begin
        for (int i = 0; i < 4; i++) begin
          cv_d[i] = cv_q[i] + wv_q[i];
        end
      end
      StOut: begin
        if (out_acc) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            cv_d[0]  = Iv0;
            cv_d[1]  = Iv1;
            cv_d[2]  = Iv2;
            cv_d[3]  = Iv3;
            bitlen_d = '0;
            pos_d    = '0;
            pad_d    = 1'b0;
            pad80_d  = 1'b0;
            lenlo_d  = 1'b0;
            fin_d    = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // block full: start compression from the current chaining values
    if (wr_en && pos_q == LenHiPos) begin
      round_d = '0;
      wv_d    = cv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      pos_q    <= '0;
      bitlen_q <= '0;
      pad_q    <= 1'b0;
      pad80_q  <= 1'b0;
      lenlo_q  <= 1'b0;
      fin_q    <= 1'b0;
      round_q  <= '0;
      oidx_q   <= '0;
      cv_q[0]  <= Iv0;
      cv_q[1]  <= Iv1;
      cv_q[2]  <= Iv2;
      cv_q[3]  <= Iv3;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      bitlen_q <= bitlen_d;
      pad_q    <= pad_d;
      pad80_q  <= pad80_d;
      lenlo_q  <= lenlo_d;
      fin_q    <= fin_d;
      round_q  <= round_d;
      oidx_q   <= oidx_d;
      cv_q     <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q <= wv_d;
  end

endmodule

// ----- rtl/md5_checker.sv -----
// Port-level checks for the MD5 digest unit, bound to the top level.
module md5_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [39:0] s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // no item taken while a digest is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while digest valid");

  // a last word always leads to padding work before the next item
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("ready right after last word");

  // the digest ends after its final word is taken
  a_end_of_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> !m_axis_tvalid_o)
    else $error("digest continues past last word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled digest item changed");

endmodule

bind md5_message_digest_unit md5_checker u_md5_checker (.*);

// ----- test/md5_digest_checker.sv -----
// Stream monitor for the MD5 digest unit: predicts digest words and compares them.
module md5_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,  // [31:0] message_word, [34:32] valid_bytes
  input  logic        s_axis_tlast_i,  // last_word
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,  // [31:0] digest_word
  input  logic        m_axis_tlast_i,  // digest_last
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o,
  output int unsigned checked_count_o
);

  localparam int unsigned ReportLimit = 10;

  localparam logic [31:0] SineK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned RotAmt [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam logic [3:0] LenLoSlot = 4'd14;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_item_t;

  logic [31:0]  chain_h [4];
  logic [31:0]  msg_blk [16];
  logic [63:0]  msg_bits;
  logic [3:0]   fill_pos;
  digest_item_t digest_q [$];
  digest_item_t want;
  int unsigned  mismatches;
  int unsigned  checked;

  function automatic void restart_digest();
    chain_h[0] = 32'h6745_2301;
    chain_h[1] = 32'hefcd_ab89;
    chain_h[2] = 32'h98ba_dcfe;
    chain_h[3] = 32'h1032_5476;
    msg_bits   = '0;
    fill_pos   = '0;
  endfunction

  function automatic void fold_block();
    logic [31:0] a, b, c, d, mix, sum;
    int unsigned pick, sh;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          mix  = (b & c) | (~b & d);
          pick = r;
        end
        1: begin
          mix  = (d & b) | (~d & c);
          pick = 5 * r + 1;
        end
        2: begin
          mix  = b ^ c ^ d;
          pick = 3 * r + 5;
        end
        default: begin
          mix  = c ^ (b | ~d);
          pick = 7 * r;
        end
      endcase
      sum = a + mix + SineK[r] + msg_blk[pick % 16];
      sh  = RotAmt[(r / 16) * 4 + r % 4];
      a   = d;
      d   = c;
      c   = b;
      b   = b + ((sum << sh) | (sum >> (32 - sh)));
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
  endfunction

  function automatic void put_block_word(logic [31:0] w);
    msg_blk[fill_pos] = w;
    fill_pos = fill_pos + 4'd1;
    if (fill_pos == 4'd0) begin
      fold_block();
    end
  endfunction

  function automatic void absorb_word(logic [31:0] word, logic [2:0] count, logic last);
    int unsigned  nbytes;
    digest_item_t item;
    nbytes = (count > 3'd4) ? 4 : count;
    if (!last) begin
      msg_bits += 64'd32;
      put_block_word(word);
    end else begin
      msg_bits += 64'(nbytes * 8);
      if (nbytes < 4) begin
        put_block_word((word & ~(32'hffff_ffff << (8 * nbytes))) | (32'h80 << (8 * nbytes)));
      end else begin
        put_block_word(word);
        put_block_word(32'h80);
      end
      while (fill_pos != LenLoSlot) begin
        put_block_word('0);
      end
      put_block_word(msg_bits[31:0]);
      put_block_word(msg_bits[63:32]);
      for (int k = 0; k < 4; k++) begin
        item.word = chain_h[k];
        item.last = (k == 3);
        digest_q.insert(digest_q.size(), item);
      end
      restart_digest();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_digest();
      digest_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        absorb_word(s_axis_tdata_i[31:0], s_axis_tdata_i[34:32], s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        checked++;
        if (digest_q.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("unexpected digest item %08h last %0b", m_axis_tdata_i, m_axis_tlast_i);
          end
          mismatches++;
        end else begin
          want = digest_q.pop_front();
          if (m_axis_tdata_i !== want.word || m_axis_tlast_i !== want.last) begin
            if (mismatches < ReportLimit) begin
              $display("digest mismatch: expected %08h last %0b, got %08h last %0b",
                       want.word, want.last, m_axis_tdata_i, m_axis_tlast_i);
            end
            mismatches++;
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= digest_q.size();
    checked_count_o  <= checked;
  end

endmodule

// ----- test/tb_md5_message_digest_unit.sv -----
// Testbench top for the MD5 digest unit: message stimulus, handshake mixes and verdict.
module tb_md5_message_digest_unit;

  localparam int unsigned TotalItems  = 170;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 200;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i  = '0;  // [31:0] message_word, [34:32] valid_bytes
  logic        s_axis_tlast_i  = 1'b0;  // last_word
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;  // [31:0] digest_word
  logic        m_axis_tlast_o;  // digest_last

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned words_sent         = 0;
  int unsigned messages_sent      = 0;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned quiet_cycles       = 0;

  md5_message_digest_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  md5_digest_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_axis_tvalid_i),
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i   (s_axis_tdata_i),
    .s_axis_tlast_i   (s_axis_tlast_i),
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i  (m_axis_tready_i),
    .m_axis_tdata_i   (m_axis_tdata_o),
    .m_axis_tlast_i   (m_axis_tlast_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  initial begin
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("no item moved for %0d cycles, %0d digest words still due", StallLimit,
             pending_count);
    $display("tb_md5_message_digest_unit NOT OK");
    $finish;
  end

  function automatic logic [31:0] random_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic [31:0] word, input logic [2:0] count, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= {5'b0, 3'($urandom_range(7)), 32'($urandom())};
      s_axis_tlast_i  <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, count, word};
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    words_sent++;
    if (last) begin
      messages_sent++;
    end
  endtask

  // mostly full body words; some bodies carry a stray byte count that must be ignored
  task automatic send_random_message();
    int unsigned body;
    body = ($urandom_range(3) == 0) ? $urandom_range(14, 33) : $urandom_range(0, 13);
    for (int i = 0; i < body; i++) begin
      send_word(random_word(), ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'd4, 1'b0);
    end
    send_word(random_word(), 3'($urandom_range(7)), 1'b1);
  endtask

  initial begin
    int unsigned directed_words;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty message, junk in the dropped bytes
    send_word(32'hffff_ffff, 3'd0, 1'b1);
    // "abc" with a junk fourth byte
    send_word(32'hee63_6261, 3'd3, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    // count above four on the last word
    send_word(32'h0000_0000, 3'd7, 1'b1);
    // short count on a body word is ignored
    send_word(32'hffff_ffff, 3'd1, 1'b0);
    send_word(32'ha5a5_a5a5, 3'd5, 1'b1);
    // last word lands in the length slot, forcing an extra block
    for (int i = 0; i < 14; i++) begin
      send_word((i % 2 == 0) ? 32'h0000_0000 : 32'hffff_ffff, 3'd4, 1'b0);
    end
    send_word(32'h1234_5678, 3'd2, 1'b1);
    directed_words = words_sent;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 69;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 69;
        end
        default: begin
          sender_idle_pct    = 17;
          receiver_stall_pct = 17;
        end
      endcase
      while (words_sent < directed_words + (phase + 1) * (TotalItems - directed_words) / 4) begin
        send_random_message();
      end
    end
    s_axis_tvalid_i <= 1'b0;

    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d message words in %0d messages under four handshake mixes",
             words_sent, messages_sent);
    $display("%0d digest words checked, %0d mismatches", checked_count, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_md5_message_digest_unit OK");
    end else begin
      $display("tb_md5_message_digest_unit NOT OK");
    end
    $finish;
  end

endmodule
